// ----- rtl/core/jss_pkg.sv -----
// jss_pkg: shared widths, constants and types of the jensen-shannon similarity core
package jss_pkg;

	// payload widths
	localparam int unsigned VALUE_W = 21;
	localparam int unsigned SIM_W   = 17;

	// fixed-point formats
	localparam int unsigned TABLE_BITS      = 16;
	localparam int unsigned INPUT_FRAC_BITS = 20;
	localparam int unsigned FRAC_BITS       = 16;
	localparam int unsigned IDX_W           = TABLE_BITS + 1;
	localparam int unsigned IDX_SHIFT       = INPUT_FRAC_BITS - TABLE_BITS;
	localparam int unsigned K_W             = $clog2(TABLE_BITS + 1);
	localparam int unsigned MANT_W          = 31;
	localparam int unsigned SQ_W            = MANT_W + 1;
	localparam int unsigned MAG_W           = $clog2((TABLE_BITS << FRAC_BITS) + 1);
	localparam int unsigned STEP_W          = $clog2(FRAC_BITS);

	// term products and accumulators
	localparam int unsigned MIX_W    = VALUE_W + 1;
	localparam int unsigned PROD_W   = MIX_W + MAG_W;
	localparam int unsigned PQ_SHIFT = INPUT_FRAC_BITS + FRAC_BITS - 32;
	localparam int unsigned M_SHIFT  = PQ_SHIFT + 1;
	localparam int unsigned TERM_W   = PROD_W - PQ_SHIFT;
	localparam int unsigned ACC_W    = 48;

	// square root
	localparam int unsigned SQRT_STEPS = ACC_W / 2;
	localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);

	localparam logic [VALUE_W-1:0] ONE_VALUE = VALUE_W'(1 << INPUT_FRAC_BITS);
	localparam logic [SIM_W-1:0]   ONE_SIM   = SIM_W'(1 << 16);
	localparam logic [MAG_W-1:0]   MAG_TOP   = MAG_W'(TABLE_BITS << FRAC_BITS);

	// accumulator memory entries
	localparam logic ACC_ENT = 1'b0;
	localparam logic ACC_MIX = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_SQUARE,
		S_MAG,
		S_MUL,
		S_ACC,
		S_FIN0,
		S_FIN1,
		S_FIN2,
		S_SQRT,
		S_DONE
	} jss_state_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_Q,
		TERM_M
	} jss_term_t;

endpackage

// ----- rtl/core/jss_ifs.sv -----
// jss_ifs: item and result channel interfaces of the jensen-shannon similarity core

interface jss_item_if import jss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] p_value;
	logic [VALUE_W-1:0] q_value;
	logic               last_element;

	modport source (output valid, output p_value, output q_value, output last_element,
		input ready);
	modport sink (input valid, input p_value, input q_value, input last_element,
		output ready);
endinterface

interface jss_result_if import jss_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SIM_W-1:0] similarity;

	modport source (output valid, output similarity, input ready);
	modport sink (input valid, input similarity, output ready);
endinterface

// ----- rtl/core/jensen_shannon_similarity_core.sv -----
// jensen_shannon_similarity_core: streamed (p, q) pairs in, 1 - sqrt(js divergence) out
//
//  channel     dir   payload                            handshake
//  item_in     in    p_value, q_value, last_element     valid / ready
//  result_out  out   similarity                         valid / ready
//
// each pair runs three log2 evaluations, paced by the shared 31x31 squaring
// multiplier (16 squarings per log) and the one-port accumulator memory; a pair
// marked last adds two reads and 24 root steps
// reset clears the control state and the accumulator valid bits; no clearing pass
// the result sits in an output register, so a stalled result_out holds only the
// final step of the next vector, not its pairs

module jensen_shannon_similarity_core import jss_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	jss_item_if.sink     item_in,
	jss_result_if.source result_out
);

	jss_state_t state_q, state_d;
	jss_term_t  term_q;

	logic [VALUE_W-1:0] p_q, q_q;
	logic               last_q;
	logic               idx_zero_q;
	logic [K_W-1:0]     k_q;
	logic [MANT_W-1:0]  x_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [STEP_W-1:0]  step_q;
	logic [MAG_W-1:0]   mag_q;
	logic [PROD_W-1:0]  prod_s1;

	logic [ACC_W-1:0] acc_mem [0:1];
	logic [ACC_W-1:0] rd_data_q;
	logic [1:0]       acc_vld_q;
	logic [ACC_W-1:0] ent_q;
	logic [ACC_W-1:0] rem_q, root_q, bit_q;
	logic [SQRT_CNT_W-1:0] sqrt_cnt_q;

	logic             out_vld_q;
	logic [SIM_W-1:0] out_sim_q;

	logic accept;
	logic rd_en, wr_en, load_out;
	logic rd_addr, term_addr;

	logic [VALUE_W-1:0] p_sat, q_sat;
	logic [MIX_W-1:0]   mix_val, cur_val;
	logic [IDX_W-1:0]   cur_idx;
	logic [K_W-1:0]     k_d;
	logic [MANT_W-1:0]  x_init, x_next;
	logic [2*MANT_W-1:0] sq_full;
	logic [SQ_W-1:0]    sq;
	logic               sq_top;
	logic [MAG_W-1:0]   mag_d;
	logic [PROD_W-1:0]  prod_d;
	logic [TERM_W-1:0]  term_val;
	logic [ACC_W-1:0]   acc_old, acc_new, mix_sum, half_e, js_d;
	logic [ACC_W:0]     acc_sum;
	logic [ACC_W-1:0]   trial;
	logic [SIM_W-1:0]   sim_d;

	assign accept = item_in.valid && item_in.ready;
	assign item_in.ready = (state_q == S_IDLE);
	assign result_out.valid = out_vld_q;
	assign result_out.similarity = out_sim_q;

	// inputs above one saturate to one
	assign p_sat = (item_in.p_value > ONE_VALUE) ? ONE_VALUE : item_in.p_value;
	assign q_sat = (item_in.q_value > ONE_VALUE) ? ONE_VALUE : item_in.q_value;

	// midpoint held as p + q with one more fraction bit
	assign mix_val = {1'b0, p_q} + {1'b0, q_q};

	// operand and table index of the current term
	always_comb begin
		unique case (term_q)
			TERM_P: begin
				cur_val   = {1'b0, p_q};
				cur_idx   = IDX_W'(p_q >> IDX_SHIFT);
				term_addr = ACC_ENT;
			end
			TERM_Q: begin
				cur_val   = {1'b0, q_q};
				cur_idx   = IDX_W'(q_q >> IDX_SHIFT);
				term_addr = ACC_ENT;
			end
			TERM_M: begin
				cur_val   = mix_val;
				cur_idx   = IDX_W'(mix_val >> (IDX_SHIFT + 1));
				term_addr = ACC_MIX;
			end
			default: begin
				cur_val   = '0;
				cur_idx   = '0;
				term_addr = ACC_ENT;
			end
		endcase
	end

	// integer part of the log: position of the top set bit
	always_comb begin
		k_d = '0;
		for (int i = 0; i < IDX_W; i++) begin
			if (cur_idx[i]) begin
				k_d = K_W'(i);
			end
		end
	end

	// mantissa normalized to q1.30
	assign x_init = MANT_W'(cur_idx) << (K_W'(MANT_W - 1) - k_d);

	// one squaring step of the fraction
	assign sq_full = {{MANT_W{1'b0}}, x_q} * {{MANT_W{1'b0}}, x_q};
	assign sq      = sq_full[MANT_W-1 +: SQ_W];
	assign sq_top  = sq[SQ_W-1];
	assign x_next  = sq_top ? sq[SQ_W-1:1] : sq[MANT_W-1:0];

	// log magnitude and term product
	assign mag_d  = idx_zero_q ? '0 : (MAG_TOP - {k_q, frac_q});
	assign prod_d = PROD_W'(cur_val) * PROD_W'(mag_q);
	assign term_val = (term_q == TERM_M) ? TERM_W'(prod_s1 >> M_SHIFT)
		: TERM_W'(prod_s1 >> PQ_SHIFT);

	// saturating accumulate of the read-back sum
	assign acc_old = acc_vld_q[term_addr] ? rd_data_q : '0;
	assign acc_sum = {1'b0, acc_old} + (ACC_W + 1)'(term_val);
	assign acc_new = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

	// divergence floored at zero
	assign mix_sum = acc_vld_q[ACC_MIX] ? rd_data_q : '0;
	assign half_e  = ent_q >> 1;
	assign js_d    = (mix_sum > half_e) ? (mix_sum - half_e) : '0;

	// root step and final similarity
	assign trial = root_q + bit_q;
	assign sim_d = (|root_q[ACC_W-1:SIM_W-1]) ? '0 : (ONE_SIM - root_q[SIM_W-1:0]);

	// next state and memory strobes
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = ACC_ENT;
		wr_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item_in.valid) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: state_d = S_SQUARE;
			S_SQUARE: begin
				if (step_q == '0) begin
					state_d = S_MAG;
				end
			end
			S_MAG: state_d = S_MUL;
			S_MUL: begin
				rd_en   = 1'b1;
				rd_addr = term_addr;
				state_d = S_ACC;
			end
			S_ACC: begin
				wr_en = 1'b1;
				if (term_q != TERM_M) begin
					state_d = S_LOAD;
				end else if (last_q) begin
					state_d = S_FIN0;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FIN0: begin
				rd_en   = 1'b1;
				rd_addr = ACC_ENT;
				state_d = S_FIN1;
			end
			S_FIN1: begin
				rd_en   = 1'b1;
				rd_addr = ACC_MIX;
				state_d = S_FIN2;
			end
			S_FIN2: state_d = S_SQRT;
			S_SQRT: begin
				if (sqrt_cnt_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_vld_q || result_out.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters, term select and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q     <= TERM_P;
			step_q     <= '0;
			sqrt_cnt_q <= '0;
			acc_vld_q  <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (accept) begin
				term_q <= TERM_P;
			end else if (state_q == S_ACC && term_q != TERM_M) begin
				term_q <= (term_q == TERM_P) ? TERM_Q : TERM_M;
			end
			if (state_q == S_LOAD) begin
				step_q <= STEP_W'(FRAC_BITS - 1);
			end else if (state_q == S_SQUARE) begin
				step_q <= step_q - 1'b1;
			end
			if (state_q == S_FIN2) begin
				sqrt_cnt_q <= SQRT_CNT_W'(SQRT_STEPS - 1);
			end else if (state_q == S_SQRT) begin
				sqrt_cnt_q <= sqrt_cnt_q - 1'b1;
			end
			if (state_q == S_FIN2) begin
				acc_vld_q <= '0;
			end else if (wr_en) begin
				acc_vld_q[term_addr] <= 1'b1;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (result_out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// accumulator memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			acc_mem[term_addr] <= acc_new;
		end
		if (rd_en) begin
			rd_data_q <= acc_mem[rd_addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q    <= p_sat;
			q_q    <= q_sat;
			last_q <= item_in.last_element;
		end
		if (state_q == S_LOAD) begin
			x_q        <= x_init;
			k_q        <= k_d;
			idx_zero_q <= (cur_idx == '0);
			frac_q     <= '0;
		end else if (state_q == S_SQUARE) begin
			x_q            <= x_next;
			frac_q[step_q] <= sq_top;
		end
		if (state_q == S_MAG) begin
			mag_q <= mag_d;
		end
		if (state_q == S_MUL) begin
			prod_s1 <= prod_d;
		end
		if (state_q == S_FIN1) begin
			ent_q <= acc_vld_q[ACC_ENT] ? rd_data_q : '0;
		end
		if (state_q == S_FIN2) begin
			rem_q  <= js_d;
			root_q <= '0;
			bit_q  <= ACC_W'(1) << (ACC_W - 2);
		end else if (state_q == S_SQRT) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (load_out) begin
			out_sim_q <= sim_d;
		end
	end

	// mantissa stays in [1,2) through the squaring steps
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQUARE && !idx_zero_q) |-> x_q[MANT_W-1])
		else $error("log mantissa lost normalization");

	// a shown result never exceeds one
	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> (result_out.similarity <= ONE_SIM))
		else $error("similarity above one");

	// both sums read as zero once a vector is finished
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN2) |=> (acc_vld_q == 2'b00))
		else $error("accumulators not cleared after last item");

	// an accepted item starts with the p term
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(item_in.valid && item_in.ready) |=> (state_q == S_LOAD && term_q == TERM_P))
		else $error("item accepted without starting the p term");

endmodule
